FILE: rtl/core/pearson_correlation_accumulator_top_assert.svh
// ============================================================================
// Assertion macros for the Pearson correlation accumulator
// Implication and next-cycle checks, compiled out for synthesis.
// ============================================================================
`ifndef PEARSON_CORRELATION_ACCUMULATOR_TOP_ASSERT_SVH
`define PEARSON_CORRELATION_ACCUMULATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PCA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pca check failed");
`define PCA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pca check failed");
`else
`define PCA_ASSERT_IMP(label, clk, rst, ante, cons)
`define PCA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/pca_pkg.sv
// ============================================================================
// Pearson correlation accumulator package
// Shared widths, beat types, operation codes and sequencer states.
// ============================================================================
package pca_pkg;

   localparam int SAMPLE_BITS         = 16;
   localparam int COUNT_BITS_DEFAULT  = 16;
   localparam int FRAC_BITS           = 14;
   localparam int CORR_BITS           = 16;
   localparam int OP_QUEUE_DEPTH      = 2;
   localparam int RSP_QUEUE_DEPTH     = 2;
   localparam int OPERAND_BITS_DEFAULT = 2 * (SAMPLE_BITS + COUNT_BITS_DEFAULT + 1) + 1;

   typedef enum logic [1:0] {
      KIND_ADD   = 2'd0,
      KIND_DROP  = 2'd1,
      KIND_EVAL  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                       kind;
      logic signed [SAMPLE_BITS-1:0]  x_value;
      logic signed [SAMPLE_BITS-1:0]  y_value;
   } req_type;

   typedef struct packed {
      logic signed [CORR_BITS-1:0] correlation;
      logic                        is_null;
   } rsp_type;

   // classified operation with the sample products already formed
   typedef struct packed {
      kind_type                        kind;
      logic signed [SAMPLE_BITS-1:0]   x;
      logic signed [SAMPLE_BITS-1:0]   y;
      logic signed [2*SAMPLE_BITS-1:0] xx;
      logic signed [2*SAMPLE_BITS-1:0] yy;
      logic signed [2*SAMPLE_BITS-1:0] xy;
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SAT,
      ST_ROOT_A,
      ST_ROOT_B,
      ST_EMIT
   } exec_state_type;

   typedef enum logic [2:0] {
      MS_N_SXX   = 3'd0,
      MS_SX_SX   = 3'd1,
      MS_N_SYY   = 3'd2,
      MS_SY_SY   = 3'd3,
      MS_N_SXY   = 3'd4,
      MS_SX_SY   = 3'd5,
      MS_VX_VY   = 3'd6,
      MS_NUM_NUM = 3'd7
   } mul_step_type;

endpackage

FILE: rtl/core/pca_fifo.sv
// ============================================================================
// Pearson correlation accumulator beat queue
// Small register queue with simultaneous push and pop.
// ============================================================================
module pca_fifo
   import pca_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/pca_front.sv
// ============================================================================
// Pearson correlation accumulator front end
// Accepts request beats and forms the sample products for the back end.
// ============================================================================
module pca_front
   import pca_pkg::*;
(
   input  logic    push,
   input  req_type req_data,
   input  logic    queue_full,
   output logic    queue_push,
   output op_type  op_data
);

   logic signed [2*SAMPLE_BITS-1:0] xx, yy, xy;

   assign xx = req_data.x_value * req_data.x_value;
   assign yy = req_data.y_value * req_data.y_value;
   assign xy = req_data.x_value * req_data.y_value;

   assign queue_push = push && !queue_full;

   always_comb begin
      op_data.kind = req_data.kind;
      op_data.x    = req_data.x_value;
      op_data.y    = req_data.y_value;
      op_data.xx   = xx;
      op_data.yy   = yy;
      op_data.xy   = xy;
   end

endmodule

FILE: rtl/core/pca_mul.sv
// ============================================================================
// Pearson correlation accumulator serial multiplier
// Unsigned shift-add multiplier, one multiplier bit per clock.
// ============================================================================
module pca_mul
   import pca_pkg::*;
#(
   parameter int WIDTH = OPERAND_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [WIDTH-1:0]   mcand,
   input  logic [WIDTH-1:0]   mplier,
   output logic               done,
   output logic [2*WIDTH-1:0] product
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [2*WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0]   mcand_ff, mcand_in;
   logic [WIDTH:0]     sum;

   assign sum     = {1'b0, acc_ff[2*WIDTH-1:WIDTH]} + (acc_ff[0] ? {1'b0, mcand_ff} : '0);
   assign done    = busy_ff && (cnt_ff == '0);
   assign product = acc_ff;

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(WIDTH);
         acc_in   = {{WIDTH{1'b0}}, mplier};
         mcand_in = mcand;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            acc_in = {sum, acc_ff[WIDTH-1:1]};
            cnt_in = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
   end

endmodule

FILE: rtl/core/pca_exec.sv
// ============================================================================
// Pearson correlation accumulator back end
// Running sums, exact evaluation through the serial multiplier and root search.
// ============================================================================
module pca_exec
   import pca_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    op_valid,
   input  op_type  op_head,
   output logic    op_pop,
   input  logic    rsp_ready,
   output logic    rsp_push,
   output rsp_type rsp_out
);

   localparam int S     = SAMPLE_BITS;
   localparam int SUM_W = S + COUNT_BITS + 1;
   localparam int SQ_W  = 2 * S + COUNT_BITS - 1;
   localparam int D_W   = 2 * SUM_W + 1;
   localparam int V_W   = 2 * D_W;
   localparam int EW    = 2 * D_W + 2 * FRAC_BITS + 3;
   localparam int BIT_W = $clog2(FRAC_BITS);

   // running sums
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic signed [SUM_W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [SQ_W-1:0]  sxx_ff, sxx_in, syy_ff, syy_in, sxy_ff, sxy_in;

   // evaluation state
   exec_state_type      state_ff, state_in;
   mul_step_type        step_ff, step_in, next_step, start_step;
   logic signed [D_W:0] term_ff, term_in;
   logic [D_W-1:0]      vx_ff, vx_in, vy_ff, vy_in, num_ff, num_in;
   logic                neg_ff, neg_in, null_ff, null_in;
   logic [V_W-1:0]      v_ff, v_in;
   logic [EW-1:0]       r_ff, r_in, p_ff, p_in, qvs_ff, qvs_in, vs_ff, vs_in, t_ff, t_in;
   logic [FRAC_BITS:0]  q_ff, q_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;

   // multiplier hookup
   logic                mul_start, mul_done, prod_sign;
   logic [D_W-1:0]      mul_a, mul_b;
   logic [2*D_W-1:0]    prod;
   logic signed [D_W:0] prod_term, diff;
   logic                diff_pos;
   logic [D_W-1:0]      diff_mag;
   logic [SQ_W-1:0]     sxx_mag, syy_mag, sxy_mag;
   logic [SUM_W-1:0]    sx_mag, sy_mag;
   logic [EW-1:0]       cand, sat_v;
   logic                accept;
   logic [CORR_BITS-1:0] q_ext;

   pca_mul #(
      .WIDTH (D_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .done    (mul_done),
      .product (prod)
   );

   assign sxx_mag = sxx_ff[SQ_W-1] ? SQ_W'(-sxx_ff) : SQ_W'(sxx_ff);
   assign syy_mag = syy_ff[SQ_W-1] ? SQ_W'(-syy_ff) : SQ_W'(syy_ff);
   assign sxy_mag = sxy_ff[SQ_W-1] ? SQ_W'(-sxy_ff) : SQ_W'(sxy_ff);
   assign sx_mag  = sx_ff[SUM_W-1] ? SUM_W'(-sx_ff) : SUM_W'(sx_ff);
   assign sy_mag  = sy_ff[SUM_W-1] ? SUM_W'(-sy_ff) : SUM_W'(sy_ff);

   assign next_step = mul_step_type'(step_ff + 3'd1);

   // operand select for the product being started
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (start_step)
         MS_N_SXX:   begin mul_a = D_W'(count_ff); mul_b = D_W'(sxx_mag); end
         MS_SX_SX:   begin mul_a = D_W'(sx_mag);   mul_b = D_W'(sx_mag);  end
         MS_N_SYY:   begin mul_a = D_W'(count_ff); mul_b = D_W'(syy_mag); end
         MS_SY_SY:   begin mul_a = D_W'(sy_mag);   mul_b = D_W'(sy_mag);  end
         MS_N_SXY:   begin mul_a = D_W'(count_ff); mul_b = D_W'(sxy_mag); end
         MS_SX_SY:   begin mul_a = D_W'(sx_mag);   mul_b = D_W'(sy_mag);  end
         MS_VX_VY:   begin mul_a = vx_ff;          mul_b = vy_ff;         end
         MS_NUM_NUM: begin mul_a = num_ff;         mul_b = num_ff;        end
         default:    begin mul_a = '0;             mul_b = '0;            end
      endcase
   end

   // sign of the product that just finished
   always_comb begin
      unique case (step_ff)
         MS_N_SXX: prod_sign = sxx_ff[SQ_W-1];
         MS_N_SYY: prod_sign = syy_ff[SQ_W-1];
         MS_N_SXY: prod_sign = sxy_ff[SQ_W-1];
         MS_SX_SY: prod_sign = sx_ff[SUM_W-1] ^ sy_ff[SUM_W-1];
         default:  prod_sign = 1'b0;
      endcase
   end

   assign prod_term = prod_sign ? -$signed({1'b0, prod[D_W-1:0]})
                                :  $signed({1'b0, prod[D_W-1:0]});
   assign diff      = term_ff - prod_term;
   assign diff_pos  = !diff[D_W] && (diff != '0);
   assign diff_mag  = diff[D_W] ? D_W'(-diff) : diff[D_W-1:0];

   assign cand   = t_ff + vs_ff;
   assign accept = (cand <= r_ff);
   assign sat_v  = EW'(v_ff) << (2 * FRAC_BITS);

   assign q_ext = CORR_BITS'(q_ff);
   always_comb begin
      rsp_out.is_null     = null_ff;
      rsp_out.correlation = null_ff ? '0 : (neg_ff ? -q_ext : q_ext);
   end

   always_comb begin
      count_in   = count_ff;
      sx_in      = sx_ff;
      sy_in      = sy_ff;
      sxx_in     = sxx_ff;
      syy_in     = syy_ff;
      sxy_in     = sxy_ff;
      state_in   = state_ff;
      step_in    = step_ff;
      term_in    = term_ff;
      vx_in      = vx_ff;
      vy_in      = vy_ff;
      num_in     = num_ff;
      neg_in     = neg_ff;
      null_in    = null_ff;
      v_in       = v_ff;
      r_in       = r_ff;
      p_in       = p_ff;
      qvs_in     = qvs_ff;
      vs_in      = vs_ff;
      t_in       = t_ff;
      q_in       = q_ff;
      bit_in     = bit_ff;
      op_pop     = 1'b0;
      rsp_push   = 1'b0;
      mul_start  = 1'b0;
      start_step = MS_N_SXX;

      unique case (state_ff)
         ST_IDLE: begin
            if (op_valid) begin
               op_pop = 1'b1;
               unique case (op_head.kind)
                  KIND_ADD: begin
                     if (!(&count_ff)) begin
                        sx_in    = sx_ff + SUM_W'(op_head.x);
                        sy_in    = sy_ff + SUM_W'(op_head.y);
                        sxx_in   = sxx_ff + SQ_W'(op_head.xx);
                        syy_in   = syy_ff + SQ_W'(op_head.yy);
                        sxy_in   = sxy_ff + SQ_W'(op_head.xy);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  KIND_DROP: begin
                     if (count_ff != '0) begin
                        sx_in    = sx_ff - SUM_W'(op_head.x);
                        sy_in    = sy_ff - SUM_W'(op_head.y);
                        sxx_in   = sxx_ff - SQ_W'(op_head.xx);
                        syy_in   = syy_ff - SQ_W'(op_head.yy);
                        sxy_in   = sxy_ff - SQ_W'(op_head.xy);
                        count_in = count_ff - 1'b1;
                     end
                  end
                  KIND_CLEAR: begin
                     sx_in    = '0;
                     sy_in    = '0;
                     sxx_in   = '0;
                     syy_in   = '0;
                     sxy_in   = '0;
                     count_in = '0;
                  end
                  KIND_EVAL: begin
                     null_in = 1'b0;
                     neg_in  = 1'b0;
                     if (count_ff < COUNT_BITS'(2)) begin
                        null_in  = 1'b1;
                        state_in = ST_EMIT;
                     end else begin
                        mul_start  = 1'b1;
                        start_step = MS_N_SXX;
                        step_in    = MS_N_SXX;
                        state_in   = ST_MUL;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               start_step = next_step;
               unique case (step_ff)
                  MS_N_SXX, MS_N_SYY, MS_N_SXY: begin
                     term_in   = prod_term;
                     mul_start = 1'b1;
                     step_in   = next_step;
                  end
                  MS_SX_SX: begin
                     if (!diff_pos) begin
                        null_in  = 1'b1;
                        state_in = ST_EMIT;
                     end else begin
                        vx_in     = diff_mag;
                        mul_start = 1'b1;
                        step_in   = next_step;
                     end
                  end
                  MS_SY_SY: begin
                     if (!diff_pos) begin
                        null_in  = 1'b1;
                        state_in = ST_EMIT;
                     end else begin
                        vy_in     = diff_mag;
                        mul_start = 1'b1;
                        step_in   = next_step;
                     end
                  end
                  MS_SX_SY: begin
                     num_in    = diff_mag;
                     neg_in    = diff[D_W];
                     mul_start = 1'b1;
                     step_in   = next_step;
                  end
                  MS_VX_VY: begin
                     v_in      = prod;
                     mul_start = 1'b1;
                     step_in   = next_step;
                  end
                  MS_NUM_NUM: begin
                     r_in     = EW'(prod) << (2 * FRAC_BITS);
                     state_in = ST_SAT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SAT: begin
            if (sat_v <= r_ff) begin
               q_in     = {1'b1, {FRAC_BITS{1'b0}}};
               state_in = ST_EMIT;
            end else begin
               q_in     = '0;
               p_in     = '0;
               qvs_in   = '0;
               vs_in    = EW'(v_ff) << (2 * (FRAC_BITS - 1));
               bit_in   = BIT_W'(FRAC_BITS - 1);
               state_in = ST_ROOT_A;
            end
         end
         ST_ROOT_A: begin
            t_in     = p_ff + qvs_ff;
            state_in = ST_ROOT_B;
         end
         ST_ROOT_B: begin
            if (accept) begin
               p_in   = cand;
               q_in   = q_ff | ((FRAC_BITS + 1)'(1) << bit_ff);
               qvs_in = (qvs_ff >> 1) + vs_ff;
            end else begin
               qvs_in = qvs_ff >> 1;
            end
            vs_in = vs_ff >> 2;
            if (bit_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               bit_in   = bit_ff - 1'b1;
               state_in = ST_ROOT_A;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= MS_N_SXX;
         count_ff <= '0;
         sx_ff    <= '0;
         sy_ff    <= '0;
         sxx_ff   <= '0;
         syy_ff   <= '0;
         sxy_ff   <= '0;
         null_ff  <= 1'b0;
         neg_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         count_ff <= count_in;
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         sxx_ff   <= sxx_in;
         syy_ff   <= syy_in;
         sxy_ff   <= sxy_in;
         null_ff  <= null_in;
         neg_ff   <= neg_in;
      end
   end

   always_ff @(posedge clock) begin
      term_ff <= term_in;
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      num_ff  <= num_in;
      v_ff    <= v_in;
      r_ff    <= r_in;
      p_ff    <= p_in;
      qvs_ff  <= qvs_in;
      vs_ff   <= vs_in;
      t_ff    <= t_in;
      q_ff    <= q_in;
      bit_ff  <= bit_in;
   end

endmodule

FILE: rtl/core/pearson_correlation_accumulator_top.sv
// ============================================================================
// Pearson correlation accumulator
// Running (x,y) sums with a Q2.14 correlation readout from exact products.
// ============================================================================
// Request beats add a sample pair, drop a pair, clear the sums or ask for the
// Pearson coefficient of the pairs held. Add, drop and clear each update the
// sums directly from the idle state, so while no evaluate holds the back end a
// steady stream of them runs at one beat per clock through a two-entry queue
// in front of the back end. An evaluate beat holds the back end while eight
// exact products, D = 2*(SAMPLE_BITS+COUNT_BITS)+3 bits per operand, go
// through one shift-add multiplier that retires one multiplier bit per clock,
// and a fourteen-step bitwise root search follows. Evaluates with fewer than
// two pairs answer null with no product formed. During an evaluate the front
// keeps taking beats until its queue fills; a finished result waits in a
// two-entry result queue, so the back end moves on while the result is not
// yet taken. An add with the count at its maximum, or a drop with no pairs
// held, is taken and ignored. The coefficient saturates at 1.0 in magnitude.
// ============================================================================
`include "pearson_correlation_accumulator_top_assert.svh"

module pearson_correlation_accumulator_top
   import pca_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   localparam int OP_W  = $bits(op_type);
   localparam int RSP_W = $bits(rsp_type);

   // front to back end queue
   logic            op_push, op_pop, op_q_full, op_q_empty;
   op_type          op_new, op_head;
   logic [OP_W-1:0] op_head_bits;

   // back end to result queue
   logic             rsp_push, rsp_q_full;
   rsp_type          rsp_out;
   logic [RSP_W-1:0] rsp_head_bits;

   assign full = op_q_full;

   // classify the beat and form the sample products
   pca_front u_front (
      .push       (push),
      .req_data   (req_data),
      .queue_full (op_q_full),
      .queue_push (op_push),
      .op_data    (op_new)
   );

   // hold classified beats while the back end is busy
   pca_fifo #(
      .WIDTH (OP_W),
      .DEPTH (OP_QUEUE_DEPTH)
   ) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_new),
      .full      (op_q_full),
      .pop       (op_pop),
      .pop_data  (op_head_bits),
      .empty     (op_q_empty)
   );

   assign op_head = op_type'(op_head_bits);

   // sums, evaluation sequencer and root search
   pca_exec #(
      .COUNT_BITS (COUNT_BITS)
   ) u_exec (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (!op_q_empty),
      .op_head   (op_head),
      .op_pop    (op_pop),
      .rsp_ready (!rsp_q_full),
      .rsp_push  (rsp_push),
      .rsp_out   (rsp_out)
   );

   // park finished results until the consumer pops them
   pca_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_out),
      .full      (rsp_q_full),
      .pop       (pop),
      .pop_data  (rsp_head_bits),
      .empty     (empty)
   );

   assign rsp_data = rsp_type'(rsp_head_bits);

   // never drop a result into a full queue
   `PCA_ASSERT_IMP(a_rsp_no_overflow, clock, reset, rsp_push, !rsp_q_full)
   // back end takes only beats that are present
   `PCA_ASSERT_IMP(a_op_pop_valid, clock, reset, op_pop, !op_q_empty)
   // a null result carries a zero coefficient
   `PCA_ASSERT_IMP(a_null_zero, clock, reset, rsp_push && rsp_out.is_null,
                   rsp_out.correlation == '0)
   // a beat pushed into an empty queue is there next clock
   `PCA_ASSERT_NXT(a_op_lands, clock, reset, op_push && op_q_empty, !op_q_empty)

endmodule
